// ===== rtl/core/fcnps_pkg.sv =====
// ----------------------------------------------------------------------------
// fcnps_pkg
// Shared types and constants of the forward cone nearest point selector:
// request and result payloads, sequencer states and the multiply unit control.
// ----------------------------------------------------------------------------
package fcnps_pkg;

    localparam int COORD_W = 24;
    localparam int STEP_W  = 20;
    localparam int COS_W   = 16;

    // Dot squared is scaled by the square of the Q1.15 cosine scale.
    localparam int COS_SQ_SHIFT = 2 * (COS_W - 1);

    // Limb width of the shared multiplier. It must hold a coordinate difference
    // and the squared cosine, which is below two to the thirtieth.
    localparam int LIMB_W = (COORD_W + 1 > COS_SQ_SHIFT) ? COORD_W + 1 : COS_SQ_SHIFT;
    localparam int OP_W   = LIMB_W + 1;
    localparam int ACC_W  = 5 * LIMB_W + 2;
    localparam int DIST_W = 2 * COORD_W + 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_JOIN_COSINE = CFG_IDX_W'(1);

    localparam logic [STEP_W-1:0] STEP_LENGTH_RESET = STEP_W'(256);
    localparam logic [COS_W-1:0]  JOIN_COSINE_RESET = COS_W'(27853);

    localparam logic [2:0] IDX_BASE_LAST   = 3'd7;
    localparam logic [2:0] IDX_CONE_A_LAST = 3'd6;
    localparam logic [2:0] IDX_CONE_B_LAST = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_z;
        logic signed [COORD_W-1:0] back_x;
        logic signed [COORD_W-1:0] back_z;
        logic signed [COORD_W-1:0] cand_x;
        logic signed [COORD_W-1:0] cand_z;
        logic                      cand_valid;
        logic                      last;
    } fcnps_in_t;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] best_x;
        logic signed [COORD_W-1:0] best_z;
    } fcnps_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_CHECK,
        ST_CONE_A,
        ST_CONE_B,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        DEST_NONE,
        DEST_DOT,
        DEST_DIFF2,
        DEST_LIM,
        DEST_DIR2,
        DEST_JC2,
        DEST_LHS,
        DEST_T,
        DEST_RHS
    } mac_dest_t;

    typedef struct packed {
        logic       issue;
        logic       clr;
        logic [1:0] shift;
        mac_dest_t  dest;
    } mac_ctl_t;

endpackage

// ===== rtl/core/fcnps_mac.sv =====
// ----------------------------------------------------------------------------
// fcnps_mac
// Shared signed multiplier with a limb-shifted wide accumulator. One partial
// product enters per cycle; the product is registered, then added into the
// accumulator at the limb offset given with the request.
// ----------------------------------------------------------------------------
module fcnps_mac
    import fcnps_pkg::*;
#(
    parameter int LIMB_W = 30
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mac_ctl_t               req,
    input  logic signed [LIMB_W:0] op_a,
    input  logic signed [LIMB_W:0] op_b,
    output mac_ctl_t               done,
    output logic [5*LIMB_W+1:0]    sum
);

    localparam int PROD_W = 2 * LIMB_W + 2;
    localparam int SUM_W  = 5 * LIMB_W + 2;

    mac_ctl_t                 ctl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]         acc_reg;
    logic [SUM_W-1:0]         acc_next;
    logic [SUM_W-1:0]         prod_ext;
    logic [SUM_W-1:0]         addend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= req;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (ctl_reg.issue) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        prod_ext = SUM_W'(prod_reg);
        case (ctl_reg.shift)
            2'd0:    addend = prod_ext;
            2'd1:    addend = prod_ext << LIMB_W;
            2'd2:    addend = prod_ext << (2 * LIMB_W);
            default: addend = prod_ext << (3 * LIMB_W);
        endcase
        acc_next = (ctl_reg.clr ? '0 : acc_reg) + addend;
    end

    assign done = ctl_reg;
    assign sum  = acc_next;

endmodule

// ===== rtl/core/forward_cone_nearest_point_select.sv =====
// ----------------------------------------------------------------------------
// forward_cone_nearest_point_select
// Keeps the nearest candidate ahead of the heading inside the join cone.
// ----------------------------------------------------------------------------
// One query is a run of requests on s_data, closed by a request with last set.
// Each request carries the endpoint, the earlier point and one candidate. The
// block answers each query with one result on m_data (found, best_x, best_z)
// after its closing request has been judged.
// Each judged request is taken in, its products are formed in ST_BASE and it is
// tested in ST_CHECK; when the cone test runs, it goes on through ST_CONE_A,
// ST_CONE_B and ST_DECIDE. Requests without a candidate or that are skipped on
// sight end in ST_IDLE. A result passes through ST_EMIT into the output register.
// All products go through a single 31 by 31 bit multiplier and one wide
// accumulator; the sequencer feeds it at most one partial product per cycle, and
// s_ready is high only between requests.
// If the receiver stalls, the result waits in the output register; the block
// keeps taking requests and holds the next result until that one is taken.
// Configuration writes (step_length, join_cosine) are taken between requests.
// Reset (aresetn low, synchronous) clears the query state and restores the
// register defaults.
// ----------------------------------------------------------------------------
module forward_cone_nearest_point_select
    import fcnps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fcnps_in_t             s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fcnps_out_t            m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    logic [STEP_W-1:0]        step_reg;
    logic signed [COS_W-1:0]  jc_reg;

    logic                      have_best_reg;
    logic                      settled_reg;
    logic signed [COORD_W-1:0] held_x_reg;
    logic signed [COORD_W-1:0] held_z_reg;
    logic [DIST_W-1:0]         held_dist_reg;

    logic signed [COORD_W-1:0] cand_x_reg;
    logic signed [COORD_W-1:0] cand_z_reg;
    logic                      last_reg;
    logic signed [COORD_W:0]   dx_reg, dz_reg, fx_reg, fz_reg;

    logic [2*LIMB_W:0]    dot_reg;
    logic [2*LIMB_W-1:0]  diff2_reg;
    logic [2*STEP_W-1:0]  lim_reg;
    logic [2*LIMB_W-1:0]  dir2_reg;
    logic [LIMB_W-1:0]    jc2_reg;
    logic [4*LIMB_W-1:0]  lhs_reg;
    logic [3*LIMB_W-1:0]  t_reg;
    logic [5*LIMB_W-1:0]  rhs_reg;

    logic       m_valid_reg;
    fcnps_out_t out_reg;

    mac_ctl_t               mac_req;
    mac_ctl_t               mac_done;
    logic signed [OP_W-1:0] mac_a, mac_b;
    logic [ACC_W-1:0]       mac_sum;

    logic   in_accept;
    logic   skip_now;
    logic   out_load;
    logic   dot_neg, near, nearer, cone_pass;
    logic   take, settle;
    state_t after_item;
    logic [LIMB_W-1:0] t_limb;
    logic [LIMB_W-1:0] diff2_limb;

    fcnps_mac #(
        .LIMB_W (LIMB_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mac_req),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .done    (mac_done),
        .sum     (mac_sum)
    );

    // Candidates that sit on the endpoint or on the earlier point, or that come
    // with a zero heading, change nothing and are dropped on arrival.
    assign skip_now = !s_data.cand_valid || settled_reg
                   || (s_data.end_x == s_data.back_x && s_data.end_z == s_data.back_z)
                   || (s_data.cand_x == s_data.end_x && s_data.cand_z == s_data.end_z)
                   || (s_data.cand_x == s_data.back_x && s_data.cand_z == s_data.back_z);

    assign dot_neg   = dot_reg[2*LIMB_W];
    assign near      = ACC_W'(diff2_reg) < (ACC_W'(lim_reg) << 1);
    assign nearer    = diff2_reg < (2*LIMB_W)'(held_dist_reg);
    assign cone_pass = (ACC_W'(lhs_reg) << COS_SQ_SHIFT) > ACC_W'(rhs_reg);
    assign after_item = last_reg ? ST_EMIT : ST_IDLE;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!skip_now) begin
                        state_next = ST_BASE;
                    end else if (s_data.last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_BASE: begin
                if (idx_reg == IDX_BASE_LAST) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!dot_neg && !near && nearer && !jc_reg[COS_W-1]) begin
                    state_next = ST_CONE_A;
                end else begin
                    state_next = after_item;
                end
            end
            ST_CONE_A: begin
                if (idx_reg == IDX_CONE_A_LAST) begin
                    state_next = ST_CONE_B;
                end
            end
            ST_CONE_B: begin
                if (idx_reg == IDX_CONE_B_LAST) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = after_item;
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        idx_next = (state_next == state_reg) ? idx_reg + 3'd1 : 3'd0;
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        in_accept = s_valid && s_ready;
        out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
        take      = 1'b0;
        settle    = 1'b0;
        case (state_reg)
            ST_CHECK: begin
                take   = !dot_neg && (near || (nearer && jc_reg[COS_W-1]));
                settle = !dot_neg && near;
            end
            ST_DECIDE: take = cone_pass;
            default: ;
        endcase
    end

    // Partial product schedule for the shared multiplier.
    always_comb begin
        mac_req    = '0;
        mac_a      = '0;
        mac_b      = '0;
        t_limb     = '0;
        diff2_limb = '0;
        case (state_reg)
            ST_BASE: begin
                mac_req.issue = 1'b1;
                case (idx_reg)
                    3'd0: begin
                        mac_a = OP_W'(fx_reg);  mac_b = OP_W'(dx_reg);  mac_req.clr = 1'b1;
                    end
                    3'd1: begin
                        mac_a = OP_W'(fz_reg);  mac_b = OP_W'(dz_reg);  mac_req.dest = DEST_DOT;
                    end
                    3'd2: begin
                        mac_a = OP_W'(fx_reg);  mac_b = OP_W'(fx_reg);  mac_req.clr = 1'b1;
                    end
                    3'd3: begin
                        mac_a = OP_W'(fz_reg);  mac_b = OP_W'(fz_reg);
                        mac_req.dest = DEST_DIFF2;
                    end
                    3'd4: begin
                        mac_a = OP_W'(step_reg);  mac_b = OP_W'(step_reg);
                        mac_req.clr = 1'b1;  mac_req.dest = DEST_LIM;
                    end
                    3'd5: begin
                        mac_a = OP_W'(dx_reg);  mac_b = OP_W'(dx_reg);  mac_req.clr = 1'b1;
                    end
                    3'd6: begin
                        mac_a = OP_W'(dz_reg);  mac_b = OP_W'(dz_reg);  mac_req.dest = DEST_DIR2;
                    end
                    default: begin
                        mac_a = OP_W'(jc_reg);  mac_b = OP_W'(jc_reg);
                        mac_req.clr = 1'b1;  mac_req.dest = DEST_JC2;
                    end
                endcase
            end
            ST_CONE_A: begin
                mac_req.issue = 1'b1;
                case (idx_reg)
                    3'd0: begin
                        mac_a = OP_W'(dot_reg[LIMB_W-1:0]);
                        mac_b = OP_W'(dot_reg[LIMB_W-1:0]);
                        mac_req.clr = 1'b1;
                    end
                    3'd1: begin
                        mac_a = OP_W'(dot_reg[LIMB_W-1:0]);
                        mac_b = OP_W'(dot_reg[2*LIMB_W-1:LIMB_W]);
                        mac_req.shift = 2'd1;
                    end
                    3'd2: begin
                        mac_a = OP_W'(dot_reg[2*LIMB_W-1:LIMB_W]);
                        mac_b = OP_W'(dot_reg[LIMB_W-1:0]);
                        mac_req.shift = 2'd1;
                    end
                    3'd3: begin
                        mac_a = OP_W'(dot_reg[2*LIMB_W-1:LIMB_W]);
                        mac_b = OP_W'(dot_reg[2*LIMB_W-1:LIMB_W]);
                        mac_req.shift = 2'd2;
                        mac_req.dest  = DEST_LHS;
                    end
                    3'd4: begin
                        mac_a = OP_W'(jc2_reg);
                        mac_b = OP_W'(dir2_reg[LIMB_W-1:0]);
                        mac_req.clr = 1'b1;
                    end
                    3'd5: begin
                        mac_a = OP_W'(jc2_reg);
                        mac_b = OP_W'(dir2_reg[2*LIMB_W-1:LIMB_W]);
                        mac_req.shift = 2'd1;
                        mac_req.dest  = DEST_T;
                    end
                    default: mac_req.issue = 1'b0;
                endcase
            end
            ST_CONE_B: begin
                // Step index packs the limb of t in its upper bits and the limb
                // of the squared distance in its lowest bit.
                case (idx_reg[2:1])
                    2'd0:    t_limb = t_reg[LIMB_W-1:0];
                    2'd1:    t_limb = t_reg[2*LIMB_W-1:LIMB_W];
                    default: t_limb = t_reg[3*LIMB_W-1:2*LIMB_W];
                endcase
                diff2_limb = idx_reg[0] ? diff2_reg[2*LIMB_W-1:LIMB_W]
                                        : diff2_reg[LIMB_W-1:0];
                if (idx_reg != IDX_CONE_B_LAST) begin
                    mac_req.issue = 1'b1;
                    mac_req.clr   = (idx_reg == 3'd0);
                    mac_req.shift = idx_reg[2:1] + {1'b0, idx_reg[0]};
                    mac_req.dest  = (idx_reg == 3'd5) ? DEST_RHS : DEST_NONE;
                    mac_a         = OP_W'(t_limb);
                    mac_b         = OP_W'(diff2_limb);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 3'd0;
            step_reg      <= STEP_LENGTH_RESET;
            jc_reg        <= JOIN_COSINE_RESET;
            have_best_reg <= 1'b0;
            settled_reg   <= 1'b0;
            held_x_reg    <= '0;
            held_z_reg    <= '0;
            held_dist_reg <= '1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_STEP_LENGTH: step_reg <= cfg_wdata[STEP_W-1:0];
                    REG_JOIN_COSINE: jc_reg   <= cfg_wdata[COS_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                have_best_reg <= 1'b0;
                settled_reg   <= 1'b0;
                held_x_reg    <= '0;
                held_z_reg    <= '0;
                held_dist_reg <= '1;
            end else if (take) begin
                have_best_reg <= 1'b1;
                held_x_reg    <= cand_x_reg;
                held_z_reg    <= cand_z_reg;
                held_dist_reg <= diff2_reg[DIST_W-1:0];
                if (settle) begin
                    settled_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cand_x_reg <= s_data.cand_x;
            cand_z_reg <= s_data.cand_z;
            last_reg   <= s_data.last;
            dx_reg     <= {s_data.end_x[COORD_W-1], s_data.end_x}
                        - {s_data.back_x[COORD_W-1], s_data.back_x};
            dz_reg     <= {s_data.end_z[COORD_W-1], s_data.end_z}
                        - {s_data.back_z[COORD_W-1], s_data.back_z};
            fx_reg     <= {s_data.cand_x[COORD_W-1], s_data.cand_x}
                        - {s_data.end_x[COORD_W-1], s_data.end_x};
            fz_reg     <= {s_data.cand_z[COORD_W-1], s_data.cand_z}
                        - {s_data.end_z[COORD_W-1], s_data.end_z};
        end
        if (mac_done.issue) begin
            case (mac_done.dest)
                DEST_DOT:   dot_reg   <= mac_sum[2*LIMB_W:0];
                DEST_DIFF2: diff2_reg <= mac_sum[2*LIMB_W-1:0];
                DEST_LIM:   lim_reg   <= mac_sum[2*STEP_W-1:0];
                DEST_DIR2:  dir2_reg  <= mac_sum[2*LIMB_W-1:0];
                DEST_JC2:   jc2_reg   <= mac_sum[LIMB_W-1:0];
                DEST_LHS:   lhs_reg   <= mac_sum[4*LIMB_W-1:0];
                DEST_T:     t_reg     <= mac_sum[3*LIMB_W-1:0];
                DEST_RHS:   rhs_reg   <= mac_sum[5*LIMB_W-1:0];
                default: ;
            endcase
        end
        if (out_load) begin
            out_reg.found  <= have_best_reg;
            out_reg.best_x <= have_best_reg ? held_x_reg : '0;
            out_reg.best_z <= have_best_reg ? held_z_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A settled query always holds a point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        settled_reg |-> have_best_reg)
        else $error("settled query without a held point");

    // Without a held point the held distance stays at infinity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !have_best_reg |-> (&held_dist_reg))
        else $error("held distance not at infinity while nothing is held");

    // A result without a point carries zero coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.found) |-> (out_reg.best_x == '0 && out_reg.best_z == '0))
        else $error("empty result with nonzero coordinates");

    // The multiplier is only driven while a candidate is being judged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mac_req.issue |-> (state_reg == ST_BASE || state_reg == ST_CONE_A
                           || state_reg == ST_CONE_B))
        else $error("multiplier issued outside a judging state");

    // Emitting a result returns to idle with the query state cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == ST_IDLE && !have_best_reg && !settled_reg && m_valid_reg))
        else $error("query state not cleared after a result");

endmodule

// ===== sim/forward_cone_nearest_point_select_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forward_cone_nearest_point_select_tb
// Self-checking bench for the forward cone nearest point selector. Queries of
// hand-built and random candidate runs are pushed through the request channel
// under bursty pacing, while the result channel stalls on its own pattern. A
// scoreboard rebuilds the chosen point of every query in exact integer math
// and compares each result field by field. The two registers are rewritten
// between phases, covering their extremes and a negative join cosine.
// ----------------------------------------------------------------------------
module forward_cone_nearest_point_select_tb;
    import fcnps_pkg::*;

    localparam int     LIMIT_CYCLES = 600000;
    localparam int     SETTLE_CYCLES = 40;
    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;
    localparam longint HELD_FAR = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;
    typedef enum {CK_END, CK_BACK, CK_EMPTY, CK_NOISE, CK_AROUND} cand_kind_t;

    class cone_scoreboard;
        fcnps_out_t              awaited_picks[$];
        int unsigned             errors;
        logic [STEP_W-1:0]       step_length;
        logic signed [COS_W-1:0] join_cosine;
        bit                      have_best;
        bit                      settled;
        longint                  held_x;
        longint                  held_z;
        longint                  held_dist;

        function new();
            errors = 0;
            step_length = STEP_LENGTH_RESET;
            join_cosine = JOIN_COSINE_RESET;
            clear_query();
        endfunction

        function void clear_query();
            have_best = 1'b0;
            settled = 1'b0;
            held_x = 0;
            held_z = 0;
            held_dist = HELD_FAR;
        endfunction

        function void take_point(longint cx, longint cz, longint dist_sq);
            have_best = 1'b1;
            held_x = cx;
            held_z = cz;
            held_dist = dist_sq;
        endfunction

        function void judge_candidate(longint ex, longint ez, longint bx, longint bz,
                                      longint cx, longint cz);
            longint      dx, dz, fx, fz, dot, diff2, dir2, near_lim, jc;
            bit [159:0]  lhs, rhs;
            dx = ex - bx;
            dz = ez - bz;
            fx = cx - ex;
            fz = cz - ez;
            if (dx == 0 && dz == 0) return;
            if (fx == 0 && fz == 0) return;
            if (cx == bx && cz == bz) return;
            dot = fx * dx + fz * dz;
            if (dot < 0) return;
            diff2 = fx * fx + fz * fz;
            near_lim = 2 * longint'(step_length) * longint'(step_length);
            if (diff2 < near_lim) begin
                take_point(cx, cz, diff2);
                settled = 1'b1;
                return;
            end
            jc = longint'(join_cosine);
            if (jc >= 0) begin
                // Squared cosine compare with both sides scaled to Q30.
                dir2 = dx * dx + dz * dz;
                lhs = dot;
                lhs = lhs * lhs;
                lhs = lhs << COS_SQ_SHIFT;
                rhs = jc * jc;
                rhs = rhs * dir2;
                rhs = rhs * diff2;
                if (lhs <= rhs) return;
            end
            if (diff2 < held_dist) take_point(cx, cz, diff2);
        endfunction

        function void note_query_request(fcnps_in_t r);
            fcnps_out_t pick;
            if (r.cand_valid && !settled)
                judge_candidate(longint'(r.end_x), longint'(r.end_z), longint'(r.back_x),
                                longint'(r.back_z), longint'(r.cand_x), longint'(r.cand_z));
            if (r.last) begin
                pick.found = have_best;
                pick.best_x = have_best ? held_x[COORD_W-1:0] : '0;
                pick.best_z = have_best ? held_z[COORD_W-1:0] : '0;
                awaited_picks.insert(awaited_picks.size(), pick);
                clear_query();
            end
        endfunction

        function void check_pick(fcnps_out_t got);
            fcnps_out_t want;
            if (awaited_picks.size() == 0) begin
                $error("unexpected result: found %0d best_x %0d best_z %0d",
                       got.found, got.best_x, got.best_z);
                errors++;
                return;
            end
            want = awaited_picks[0];
            awaited_picks.delete(0);
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.best_x !== want.best_x) begin
                $error("best_x: expected %0d, got %0d", want.best_x, got.best_x);
                errors++;
            end
            if (got.best_z !== want.best_z) begin
                $error("best_z: expected %0d, got %0d", want.best_z, got.best_z);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_picks.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    fcnps_in_t             s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    fcnps_out_t            m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cone_scoreboard sb;
    int             cycle_count = 0;
    int             burst_left = 0;
    int             items_sent = 0;
    rx_mode_t       rx_mode = RX_OPEN;
    int             rx_left = 0;

    forward_cone_nearest_point_select dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver switches between open, coin-flip, sparse and blocky stalls.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= rx_left[4];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_pick(m_data);
    end

    function automatic longint spread(input int unsigned sh);
        return longint'($urandom_range(0, 2 << sh)) - (longint'(1) << sh);
    endfunction

    function automatic fcnps_in_t make_request(longint ex, longint ez, longint bx, longint bz,
                                               longint cx, longint cz, bit cv, bit lst);
        fcnps_in_t r;
        r.end_x = ex[COORD_W-1:0];
        r.end_z = ez[COORD_W-1:0];
        r.back_x = bx[COORD_W-1:0];
        r.back_z = bz[COORD_W-1:0];
        r.cand_x = cx[COORD_W-1:0];
        r.cand_z = cz[COORD_W-1:0];
        r.cand_valid = cv;
        r.last = lst;
        return r;
    endfunction

    // Valid is left high after acceptance; the pacing decides when it drops.
    task automatic push_request(input fcnps_in_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_data <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_query_request(r);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [STEP_W-1:0] step,
                                  input logic signed [COS_W-1:0] cosv);
        cfg_index <= REG_STEP_LENGTH;
        cfg_wdata <= CFG_DATA_W'(step);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_JOIN_COSINE;
        cfg_wdata <= {{(CFG_DATA_W - COS_W){1'b0}}, cosv};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.step_length = step;
        sb.join_cosine = cosv;
    endtask

    task automatic pick_frame(output longint ex, output longint ez,
                              output longint bx, output longint bz);
        int hs;
        ex = spread(21);
        ez = spread(21);
        if ($urandom_range(0, 9) == 0) begin
            bx = ex;
            bz = ez;
        end else begin
            hs = $urandom_range(0, 16);
            bx = ex - spread(hs);
            bz = ez - spread(hs);
        end
    endtask

    task automatic run_directed();
        // Heading along +x from (-256, 0) to the origin.
        push_request(make_request(0, 0, -256, 0, 0, 0, 1'b0, 1'b1));
        push_request(make_request(1000, 1000, 1000, 1000, 2000, 1000, 1'b1, 1'b1));
        push_request(make_request(0, 0, -256, 0, 0, 0, 1'b1, 1'b0));
        push_request(make_request(0, 0, -256, 0, -256, 0, 1'b1, 1'b0));
        push_request(make_request(0, 0, -256, 0, -1000, 0, 1'b1, 1'b0));
        push_request(make_request(0, 0, -256, 0, 1000, 1000, 1'b1, 1'b1));
        push_request(make_request(0, 0, -256, 0, 2000, 100, 1'b1, 1'b0));
        push_request(make_request(0, 0, -256, 0, 1000, 50, 1'b1, 1'b0));
        push_request(make_request(0, 0, -256, 0, 3000, 0, 1'b1, 1'b1));
        // A point within the near limit of the endpoint settles the query for good.
        push_request(make_request(0, 0, -256, 0, 300, 0, 1'b1, 1'b0));
        push_request(make_request(0, 0, -256, 0, 100, 0, 1'b1, 1'b0));
        push_request(make_request(0, 0, -256, 0, 0, 0, 1'b0, 1'b1));
        push_request(make_request(0, 0, -256, 0, 1000, 0, 1'b1, 1'b0));
        push_request(make_request(5000, 5000, 5000, 4000, 5000, 5500, 1'b1, 1'b0));
        push_request(make_request(5000, 5000, 5000, 4000, 0, 0, 1'b0, 1'b1));
        push_request(make_request(0, 0, -256, 0, 0, 1000, 1'b1, 1'b1));
        push_request(make_request(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                  COORD_MIN, COORD_MAX, 1'b1, 1'b0));
        push_request(make_request(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                  COORD_MAX, COORD_MIN + 1, 1'b1, 1'b1));
        push_request(make_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MAX, 1'b1, 1'b1));
    endtask

    task automatic run_query();
        fcnps_in_t  r;
        longint     ex, ez, bx, bz, cx, cz, ox, oz;
        int         n, os;
        bit         noisy;
        cand_kind_t kind;
        int         roll;
        n = $urandom_range(1, 8);
        noisy = ($urandom_range(0, 9) == 0);
        pick_frame(ex, ez, bx, bz);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) pick_frame(ex, ez, bx, bz);
            roll = $urandom_range(0, 99);
            if (noisy || roll < 6) kind = CK_NOISE;
            else if (roll < 14) kind = CK_END;
            else if (roll < 20) kind = CK_BACK;
            else if (roll < 26) kind = CK_EMPTY;
            else kind = CK_AROUND;
            cx = ex;
            cz = ez;
            case (kind)
                CK_BACK: begin
                    cx = bx;
                    cz = bz;
                end
                CK_AROUND, CK_EMPTY: begin
                    os = $urandom_range(4, 22);
                    ox = spread(os);
                    oz = spread(os);
                    // Mostly steer the candidate ahead of the heading.
                    if (ox * (ex - bx) + oz * (ez - bz) < 0 && $urandom_range(0, 9) < 7) begin
                        ox = -ox;
                        oz = -oz;
                    end
                    cx = ex + ox;
                    cz = ez + oz;
                end
                default: ;
            endcase
            r = make_request(ex, ez, bx, bz, cx, cz, kind != CK_EMPTY, i == n - 1);
            if (kind == CK_NOISE) begin
                r.end_x = COORD_W'($urandom());
                r.end_z = COORD_W'($urandom());
                r.back_x = COORD_W'($urandom());
                r.back_z = COORD_W'($urandom());
                r.cand_x = COORD_W'($urandom());
                r.cand_z = COORD_W'($urandom());
                r.cand_valid = 1'($urandom_range(0, 1));
                if (noisy && i != n - 1) r.last = ($urandom_range(0, 3) == 0);
            end
            push_request(r);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        bit paused;
        target = items_sent + count;
        paused = 1'b0;
        while (items_sent < target) begin
            run_query();
            // Hold the sender once per phase until the block has answered all.
            if (!paused && items_sent >= target - count / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        logic [STEP_W-1:0]       step;
        logic signed [COS_W-1:0] cosv;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_STEP_LENGTH;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(200);
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin step = '0; cosv = 16'sh7FFF; end
                1: begin step = '1; cosv = 16'sh8000; end
                2: begin step = STEP_LENGTH_RESET; cosv = '0; end
                3: begin
                    step = STEP_W'($urandom_range(0, 4095));
                    cosv = -COS_W'($urandom_range(1, 32767));
                end
                default: begin
                    step = STEP_W'($urandom_range(0, 1048575));
                    cosv = COS_W'($urandom_range(0, 32767));
                end
            endcase
            drain_results();
            write_settings(step, cosv);
            run_random(180);
        end

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fcnps_pkg.sv
rtl/core/fcnps_mac.sv
rtl/core/forward_cone_nearest_point_select.sv
sim/forward_cone_nearest_point_select_tb.sv
